[hw/rtl/biq_pkg.sv]
// ----------------------------------------------------------------------------
// biquad filter package
// widths, register indexes, payload and coefficient types shared by the core
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int INNER_BITS     = SAMPLE_BITS + 8;
  localparam int COEF_BITS      = 18;
  localparam int COEF_FRAC_BITS = 14;
  localparam int PROD_BITS      = COEF_BITS + INNER_BITS;
  // three products summed, two guard bits
  localparam int ACC_BITS       = PROD_BITS + 2;
  localparam int CFG_IDX_BITS   = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_FF0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FF1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FF2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FB1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FB2 = 3'd4;

  // 1.0 in q3.14
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = 18'sd16384;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          buffer_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          buffer_end_out;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] ff0;
    logic signed [COEF_BITS-1:0] ff1;
    logic signed [COEF_BITS-1:0] ff2;
    logic signed [COEF_BITS-1:0] fb1;
    logic signed [COEF_BITS-1:0] fb2;
  } coef_set_t;

  // one multiply issue: valid, and whether it starts a new sum
  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctrl_t;

endpackage

[hw/rtl/biq_coef_regs.sv]
// ----------------------------------------------------------------------------
// biquad coefficient registers
// decodes configuration writes into the five q3.14 coefficients
// ----------------------------------------------------------------------------
module biq_coef_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [biq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [biq_pkg::COEF_BITS-1:0]        cfg_data,
  output biq_pkg::coef_set_t                   coef
);
  import biq_pkg::*;

  coef_set_t coef_r;

  assign cfg_ready = 1'b1;
  assign coef      = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.ff0 <= COEF_ONE;
      coef_r.ff1 <= '0;
      coef_r.ff2 <= '0;
      coef_r.fb1 <= '0;
      coef_r.fb2 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FF0: coef_r.ff0 <= $signed(cfg_data);
        REG_FF1: coef_r.ff1 <= $signed(cfg_data);
        REG_FF2: coef_r.ff2 <= $signed(cfg_data);
        REG_FB1: coef_r.fb1 <= $signed(cfg_data);
        REG_FB2: coef_r.fb2 <= $signed(cfg_data);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

[hw/rtl/biq_mac.sv]
// ----------------------------------------------------------------------------
// biquad multiply-accumulate unit
// registered 18 x 24 signed product followed by a 44-bit accumulator
// ----------------------------------------------------------------------------
module biq_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  biq_pkg::mac_ctrl_t                   ctrl,
  input  logic signed [biq_pkg::COEF_BITS-1:0]  coef,
  input  logic signed [biq_pkg::INNER_BITS-1:0] data,
  output logic signed [biq_pkg::ACC_BITS-1:0]   acc
);
  import biq_pkg::*;

  logic signed [PROD_BITS-1:0] prod_r;
  mac_ctrl_t                   ctrl_d_r;
  logic signed [ACC_BITS-1:0]  acc_r;
  logic signed [ACC_BITS-1:0]  acc_base;
  logic signed [ACC_BITS-1:0]  acc_nxt;

  assign acc_base = ctrl_d_r.first ? '0 : acc_r;
  assign acc_nxt  = acc_base + ACC_BITS'(prod_r);
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_d_r <= '0;
    end else begin
      ctrl_d_r <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      prod_r <= coef * data;
    end
    if (ctrl_d_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

[hw/rtl/biquad_iir_filter_core.sv]
// ----------------------------------------------------------------------------
// biquad iir filter core
// direct form ii second-order section on one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// one item at a time: a new item is accepted only back in S_IDLE; its five
// products go one by one through the single multiplier, with two pipeline drains,
// a saturation step for w and a final step that clamps y, held while the output stalls
// reset (rst_n low, synchronous): feedforward_zero = 1.0, other coefficients
//   zero, both delays cleared, no result pending
module biquad_iir_filter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  biq_pkg::in_item_t                in_data,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output biq_pkg::out_item_t               out_data,
  // coefficient writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [biq_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [biq_pkg::COEF_BITS-1:0]    cfg_data
);
  import biq_pkg::*;

  localparam int DIFF_BITS = ACC_BITS + 1;

  // sequencer steps; each issue state feeds one product into the mac
  typedef enum logic [3:0] {
    S_IDLE,   // wait for an item, issue fb1*z1 on accept
    S_FB2,    // issue fb2*z2
    S_FBW,    // drain the mac
    S_W,      // form and clamp the inner value w
    S_FF0,    // issue ff0*w
    S_FF1,    // issue ff1*z1
    S_FF2,    // issue ff2*z2
    S_FFW,    // drain the mac
    S_OUT     // clamp y, load the output register, shift the delays
  } state_t;

  state_t                          state_r;
  coef_set_t                       coef;
  mac_ctrl_t                       mac_ctrl;
  logic signed [COEF_BITS-1:0]     mac_coef;
  logic signed [INNER_BITS-1:0]    mac_data;
  logic signed [ACC_BITS-1:0]      acc;

  logic signed [SAMPLE_BITS-1:0]   x_r;
  logic                            end_r;
  logic signed [INNER_BITS-1:0]    z1_r;
  logic signed [INNER_BITS-1:0]    z2_r;
  logic signed [INNER_BITS-1:0]    w_r;
  logic                            out_valid_r;
  out_item_t                       out_data_r;

  logic signed [ACC_BITS-1:0]      acc_sh;
  logic signed [DIFF_BITS-1:0]     diff;
  logic signed [INNER_BITS-1:0]    w_nxt;
  logic signed [SAMPLE_BITS-1:0]   y_nxt;
  logic                            in_acc;
  logic                            out_free;

  biq_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  biq_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .coef  (mac_coef),
    .data  (mac_data),
    .acc   (acc)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // operand selection for the shared multiplier
  always_comb begin
    mac_ctrl = '0;
    mac_coef = coef.fb1;
    mac_data = z1_r;
    unique case (state_r)
      S_IDLE: begin
        mac_ctrl.valid = in_acc;
        mac_ctrl.first = 1'b1;
      end
      S_FB2: begin
        mac_ctrl.valid = 1'b1;
        mac_coef       = coef.fb2;
        mac_data       = z2_r;
      end
      S_FF0: begin
        mac_ctrl.valid = 1'b1;
        mac_ctrl.first = 1'b1;
        mac_coef       = coef.ff0;
        mac_data       = w_r;
      end
      S_FF1: begin
        mac_ctrl.valid = 1'b1;
        mac_coef       = coef.ff1;
        mac_data       = z1_r;
      end
      S_FF2: begin
        mac_ctrl.valid = 1'b1;
        mac_coef       = coef.ff2;
        mac_data       = z2_r;
      end
      default: ;
    endcase
  end

  // arithmetic shift floors toward minus infinity
  assign acc_sh = acc >>> COEF_FRAC_BITS;
  assign diff   = DIFF_BITS'(x_r) - DIFF_BITS'(acc_sh);

  // inner value clamp: overflow when the bits above the sign disagree
  always_comb begin
    if (diff[DIFF_BITS-1:INNER_BITS-1] == '0 || diff[DIFF_BITS-1:INNER_BITS-1] == '1) begin
      w_nxt = diff[INNER_BITS-1:0];
    end else if (diff[DIFF_BITS-1]) begin
      w_nxt = {1'b1, {(INNER_BITS-1){1'b0}}};
    end else begin
      w_nxt = {1'b0, {(INNER_BITS-1){1'b1}}};
    end
  end

  // output clamp to the sample range
  always_comb begin
    if (acc_sh[ACC_BITS-1:SAMPLE_BITS-1] == '0 || acc_sh[ACC_BITS-1:SAMPLE_BITS-1] == '1) begin
      y_nxt = acc_sh[SAMPLE_BITS-1:0];
    end else if (acc_sh[ACC_BITS-1]) begin
      y_nxt = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_nxt = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      z1_r        <= '0;
      z2_r        <= '0;
    end else begin
      // a new result may replace a taken one in the same cycle
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r     <= in_data.sample_in;
            end_r   <= in_data.buffer_end;
            state_r <= S_FB2;
          end
        end
        S_FB2: state_r <= S_FBW;
        S_FBW: state_r <= S_W;
        S_W: begin
          w_r     <= w_nxt;
          state_r <= S_FF0;
        end
        S_FF0: state_r <= S_FF1;
        S_FF1: state_r <= S_FF2;
        S_FF2: state_r <= S_FFW;
        S_FFW: state_r <= S_OUT;
        S_OUT: begin
          // hold here until the previous item has been taken
          if (out_free) begin
            out_data_r.sample_out     <= y_nxt;
            out_data_r.buffer_end_out <= end_r;
            z2_r                      <= z1_r;
            z1_r                      <= w_r;
            state_r                   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a new result only appears out of the final step
  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the final step");

  // a pending result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ready) |=> (state_r == S_OUT && $stable(out_data_r)))
    else $error("pending result overwritten");

  // delays move only when a result is produced
  a_delay_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_OUT) |=> ($stable(z1_r) && $stable(z2_r)))
    else $error("delay line changed mid-item");

  // after an accept the block is busy for the next item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (!in_ready && state_r == S_FB2))
    else $error("sequencer did not start after accept");

endmodule

[tb/tb_biquad_iir_filter_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad iir filter core testbench
// random and directed samples through the core under changing coefficient
// sets, with idling and back-pressure on both sides; every result is checked
// against a bit-true filter kept in the scoreboard
// ----------------------------------------------------------------------------

module tb_biquad_iir_filter_core;
  import biq_pkg::*;

  // scoreboard: a bit-true copy of the filter plus the queue of filtered
  // samples still waiting to come out of the core
  class biquad_scoreboard;

    longint     ff0, ff1, ff2, fb1, fb2;
    longint     delay_a, delay_b;
    out_item_t  filtered_q[$];
    int         errors;
    int         seen;

    function new();
      ff0     = longint'(COEF_ONE);
      ff1     = 0;
      ff2     = 0;
      fb1     = 0;
      fb2     = 0;
      delay_a = 0;
      delay_b = 0;
      errors  = 0;
      seen    = 0;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at result %0d: %s", seen, what);
    endtask

    function longint clamp(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // indexes past the last register are ignored
    function void set_coef(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
      longint c;
      c = longint'($signed(data));
      case (idx)
        REG_FF0: ff0 = c;
        REG_FF1: ff1 = c;
        REG_FF2: ff2 = c;
        REG_FB1: fb1 = c;
        REG_FB2: fb2 = c;
        default: ;
      endcase
    endfunction

    // feedback stage, saturated inner value, feedforward stage, then shift delays
    function void note_sample(in_item_t it);
      longint    x, fb, w, ff, y;
      out_item_t res;
      x  = longint'($signed(it.sample_in));
      fb = fb1 * delay_a + fb2 * delay_b;
      w  = clamp(x - (fb >>> COEF_FRAC_BITS), INNER_BITS);
      ff = ff0 * w + ff1 * delay_a + ff2 * delay_b;
      y  = clamp(ff >>> COEF_FRAC_BITS, SAMPLE_BITS);
      delay_b = delay_a;
      delay_a = w;
      res.sample_out     = SAMPLE_BITS'(y);
      res.buffer_end_out = it.buffer_end;
      filtered_q.push_back(res);
    endfunction

    task check_sample(out_item_t got);
      out_item_t want;
      if (filtered_q.size() == 0) begin
        report("result with no sample pending");
      end else begin
        want = filtered_q.pop_front();
        if (got.sample_out !== want.sample_out)
          report($sformatf("sample_out got %0d want %0d",
                           $signed(got.sample_out), $signed(want.sample_out)));
        if (got.buffer_end_out !== want.buffer_end_out)
          report($sformatf("buffer_end_out got %b want %b",
                           got.buffer_end_out, want.buffer_end_out));
      end
      seen++;
    endtask

    function int pending();
      return filtered_q.size();
    endfunction

    task check_drained();
      if (filtered_q.size() != 0)
        report($sformatf("%0d filtered samples never came out", filtered_q.size()));
    endtask

  endclass

  // coefficient sets the random phases choose from
  typedef enum int {COEFS_SMOOTH, COEFS_WILD, COEFS_RESONANT} coef_kind_t;

  localparam logic signed [COEF_BITS-1:0]   COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0]   COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam int SAMPLE_MAX    = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAMPLE_MIN    = -(1 << (SAMPLE_BITS - 1));
  localparam int REG_COUNT     = 5;
  localparam int REG_LAST_IDX  = (1 << CFG_IDX_BITS) - 1;
  localparam int COEF_SET_BITS = $bits(coef_set_t);
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 200;
  localparam int HOLD_CYCLES   = 200;
  // give the core margin after the drain before touching registers
  localparam int SETTLE_CYCLES = 12;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COEF_BITS-1:0]    cfg_data  = '0;

  // receiver idling and long hold-off requests, driven from the main sequence
  int rx_idle_pct = 86;
  int hold_tag    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  biquad_scoreboard sb;

  biquad_iir_filter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random ready, or a long hold-off counted here when requested
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // result monitor, every accepted result goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_sample(out_data);
  end

  // generous limit, far above the slowest correct run
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic in_item_t make_item(int s, bit be);
    in_item_t it;
    it.sample_in  = SAMPLE_BITS'(s);
    it.buffer_end = be;
    return it;
  endfunction

  // mostly full-range samples, some quiet ones and some at the rails, zero or minus one
  function automatic in_item_t pick_sample();
    int sel;
    int s;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      s = int'($urandom);
    end else if (sel < 85) begin
      s = int'($urandom_range(0, 512)) - 256;
    end else begin
      case ($urandom_range(0, 3))
        0:       s = SAMPLE_MAX;
        1:       s = SAMPLE_MIN;
        2:       s = 0;
        default: s = -1;
      endcase
    end
    return make_item(s, $urandom_range(0, 15) == 0);
  endfunction

  // smooth and resonant sets stay stable, wild sets hit saturation often
  function automatic coef_set_t pick_coefs(coef_kind_t kind);
    coef_set_t c;
    int        b1, b2, lim;
    case (kind)
      COEFS_WILD: begin
        c = COEF_SET_BITS'({$urandom, $urandom, $urandom});
      end
      COEFS_RESONANT: begin
        b2   = int'($urandom_range(14000, 16200));
        lim  = 16384 + b2 - 200;
        b1   = int'($urandom_range(0, 2 * lim)) - lim;
        c.ff0 = COEF_BITS'(int'($urandom_range(0, 4000)) - 2000);
        c.ff1 = COEF_BITS'(int'($urandom_range(0, 4000)) - 2000);
        c.ff2 = COEF_BITS'(int'($urandom_range(0, 4000)) - 2000);
        c.fb1 = COEF_BITS'(b1);
        c.fb2 = COEF_BITS'(b2);
      end
      default: begin
        b2   = int'($urandom_range(0, 27000)) - 12000;
        lim  = 16384 + b2 - 400;
        b1   = int'($urandom_range(0, 2 * lim)) - lim;
        c.ff0 = COEF_BITS'(int'($urandom_range(0, 40000)) - 20000);
        c.ff1 = COEF_BITS'(int'($urandom_range(0, 40000)) - 20000);
        c.ff2 = COEF_BITS'(int'($urandom_range(0, 40000)) - 20000);
        c.fb1 = COEF_BITS'(b1);
        c.fb2 = COEF_BITS'(b2);
      end
    endcase
    return c;
  endfunction

  // one register write, valid stays up for a following write
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_coef(idx, data);
  endtask

  // all five coefficients, sometimes a write to an unused index as well
  task automatic load_coefs(coef_set_t c, bit poke_unused);
    write_reg(REG_FF0, c.ff0);
    write_reg(REG_FF1, c.ff1);
    write_reg(REG_FF2, c.ff2);
    if (poke_unused)
      write_reg(CFG_IDX_BITS'($urandom_range(REG_COUNT, REG_LAST_IDX)), COEF_BITS'($urandom));
    write_reg(REG_FB1, c.fb1);
    write_reg(REG_FB2, c.fb2);
    cfg_valid <= 1'b0;
  endtask

  // offer one item after an optional gap, return at the edge it is taken
  task automatic send_sample(in_item_t it, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(it);
  endtask

  // stop offering and wait until every filtered sample is out
  task automatic drain_input();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_input();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    coef_set_t c;
    int        tx_idle_pct;
    int        gap;

    sb = new();
    tx_idle_pct = 24;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // passthrough after reset: rails, zero, one lsb and alternating bits
    send_sample(make_item(SAMPLE_MAX, 1'b1), 0);
    send_sample(make_item(SAMPLE_MIN, 1'b0), 0);
    send_sample(make_item(0, 1'b0), 1);
    send_sample(make_item(-1, 1'b0), 0);
    send_sample(make_item(1, 1'b0), 3);
    send_sample(make_item(int'(16'h5555), 1'b0), 0);
    send_sample(make_item(int'(16'haaaa), 1'b1), 0);
    settle();

    // largest gains and most negative feedback: inner value and output saturate
    c = '{ff0: COEF_MAX, ff1: COEF_MAX, ff2: COEF_MAX, fb1: COEF_MIN, fb2: COEF_MIN};
    load_coefs(c, 1'b1);
    repeat (4) send_sample(make_item(SAMPLE_MAX, 1'b0), 0);
    send_sample(make_item(SAMPLE_MIN, 1'b1), 0);
    send_sample(make_item(SAMPLE_MIN, 1'b0), 2);
    settle();

    // most negative gains and largest feedback: alternating overflow both ways
    c = '{ff0: COEF_MIN, ff1: COEF_MIN, ff2: COEF_MIN, fb1: COEF_MAX, fb2: COEF_MAX};
    load_coefs(c, 1'b1);
    send_sample(make_item(SAMPLE_MIN, 1'b0), 0);
    send_sample(make_item(SAMPLE_MAX, 1'b0), 0);
    send_sample(make_item(SAMPLE_MIN, 1'b1), 0);
    send_sample(make_item(SAMPLE_MAX, 1'b0), 0);
    send_sample(make_item(0, 1'b0), 0);
    send_sample(make_item(-1, 1'b1), 0);
    settle();

    // random phases, idling: sender light / receiver heavy, swapped, then none
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        tx_idle_pct = 24;
        rx_idle_pct <= 86;
      end else if (p < 6) begin
        tx_idle_pct = 86;
        rx_idle_pct <= 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      load_coefs(pick_coefs(coef_kind_t'(p % 3)), 1'($urandom_range(0, 1)));

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver hold-off while items keep coming, core fills and stalls
        if (p == 6 && i == 50)
          hold_tag <= hold_tag + 1;
        // sender waits until everything is out, then picks up again
        if (p == 4 && i == 100)
          drain_input();
        // idle cycles drawn one by one at the sender's idle rate
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
          gap++;
        send_sample(pick_sample(), gap);
      end
      settle();
    end

    // drained already, wait one more settle period for stray results
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/biq_pkg.sv
hw/rtl/biq_coef_regs.sv
hw/rtl/biq_mac.sv
hw/rtl/biquad_iir_filter_core.sv
tb/tb_biquad_iir_filter_core.sv
